// File: hdl/pvcn_pkg.sv
// Package for the plasma velocity update block.
// Holds shared types, register indexes and fixed constants; no dependencies.
package pvcn_pkg;

    typedef enum logic {
        MODE_LOAD = 1'b0,
        MODE_STEP = 1'b1
    } t_mode;

    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLS    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 8'd3;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;

    // quotient bits of the drive term, and split point of its product
    localparam int H_STEPS = 32;
    localparam int H_SPLIT = 16;

    typedef struct packed {
        logic [31:0] damping;
        logic [31:0] drive;
        logic [6:0]  cols;
        logic [6:0]  rows;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{damping: 32'd32768, drive: 32'd0,
                                   cols: 7'd64, rows: 7'd64};

    typedef struct packed {
        t_mode              mode;
        logic               in_range;
        logic               interior;
        logic [30:0]        nu;
        logic signed [31:0] ex;
        logic signed [31:0] ey;
        logic signed [31:0] ivx;
        logic signed [31:0] ivy;
    } t_item;

    typedef struct packed {
        logic clearing;
        logic adv_head;
    } t_back_status;

endpackage

// File: hdl/pvcn_if.sv
// Valid/ready channel interfaces: node input, velocity result, register write.
// No dependencies.
interface pvcn_in_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic [5:0]         col;
    logic [5:0]         row;
    logic [30:0]        coll_freq;
    logic signed [31:0] field_x;
    logic signed [31:0] field_y;
    logic signed [31:0] init_vel_x;
    logic signed [31:0] init_vel_y;
    modport source (output valid, mode, col, row, coll_freq, field_x, field_y,
                    init_vel_x, init_vel_y, input ready);
    modport sink (input valid, mode, col, row, coll_freq, field_x, field_y,
                  init_vel_x, init_vel_y, output ready);
endinterface

interface pvcn_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] vel_x_out;
    logic signed [31:0] vel_y_out;
    logic               saturated;
    modport source (output valid, vel_x_out, vel_y_out, saturated, input ready);
    modport sink (input valid, vel_x_out, vel_y_out, saturated, output ready);
endinterface

interface pvcn_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/pvcn_front.sv
// Front end: accepts node items, classifies them and queues them.
// Depends on pvcn_pkg and pvcn_in_if.
module pvcn_front import pvcn_pkg::*; #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64,
    localparam int IW = $clog2(MAX_COLS * MAX_ROWS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pvcn_in_if.sink       i_in,
    input  t_cfg          i_cfg,
    input  logic          i_clearing,
    input  logic          i_pop,
    output logic          o_q_valid,
    output t_item         o_q_item,
    output logic [IW-1:0] o_q_idx
);

    t_item             r_q_item [Q_DEPTH];
    logic [IW-1:0]     r_q_idx  [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_PTR_W:0]  r_count;

    t_item       cls;
    logic [31:0] idx_full;
    logic [7:0]  col_p2, row_p2;
    logic        push;

    always_comb begin
        col_p2 = {2'b00, i_in.col} + 8'd2;
        row_p2 = {2'b00, i_in.row} + 8'd2;
        idx_full = 32'(i_in.row) * 32'(MAX_COLS) + 32'(i_in.col);
        cls.mode     = t_mode'(i_in.mode);
        cls.in_range = (32'(i_in.col) < 32'(MAX_COLS)) && (32'(i_in.row) < 32'(MAX_ROWS));
        cls.interior = (i_in.col != 6'd0) && (i_in.row != 6'd0) &&
                       (col_p2 <= {1'b0, i_cfg.cols}) && (row_p2 <= {1'b0, i_cfg.rows});
        cls.nu  = i_in.coll_freq;
        cls.ex  = i_in.field_x;
        cls.ey  = i_in.field_y;
        cls.ivx = i_in.init_vel_x;
        cls.ivy = i_in.init_vel_y;
    end

    assign i_in.ready = (r_count != (Q_PTR_W+1)'(Q_DEPTH)) && !i_clearing;
    assign push       = i_in.valid && i_in.ready;
    assign o_q_valid  = (r_count != '0);
    assign o_q_item   = r_q_item[r_rd_ptr];
    assign o_q_idx    = r_q_idx[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop) r_rd_ptr <= r_rd_ptr + 1'b1;
            if (push && !i_pop) r_count <= r_count + 1'b1;
            else if (!push && i_pop) r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_item[r_wr_ptr] <= cls;
            r_q_idx[r_wr_ptr]  <= idx_full[IW-1:0];
        end
    end

endmodule

// File: hdl/pvcn_div.sv
// Coefficient pipeline: 1+a*nu, then both reciprocal quotients one bit per stage.
// Depends on pvcn_pkg.
module pvcn_div import pvcn_pkg::*; #(
    parameter int NODES = 4096,
    parameter int FRAC_BITS = 16,
    localparam int IW = $clog2(NODES),
    localparam int GSTEPS = FRAC_BITS + 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_valid,
    input  t_item             i_item,
    input  logic [IW-1:0]     i_idx,
    input  logic [31:0]       i_damping,
    input  logic [31:0]       i_drive,
    output logic              o_valid,
    output t_item             o_item,
    output logic [IW-1:0]     o_idx,
    output logic [GSTEPS-1:0] o_qg,
    output logic [31:0]       o_qh
);

    localparam int F  = FRAC_BITS;
    localparam int DW = 64 - F;
    localparam logic [DW-1:0] ONE_D  = DW'(1) << F;
    localparam logic [DW-1:0] HALF_D = DW'(1) << (F - 1);

    logic              r_valid [H_STEPS+1];
    t_item             r_item  [H_STEPS+1];
    logic [IW-1:0]     r_idx   [H_STEPS+1];
    logic [DW-1:0]     r_d     [H_STEPS+1];
    logic [DW-1:0]     r_rh    [H_STEPS+1];
    logic [DW-1:0]     r_rg    [H_STEPS+1];
    logic [31:0]       r_num   [H_STEPS+1];
    logic [31:0]       r_qh    [H_STEPS+1];
    logic [GSTEPS-1:0] r_qg    [H_STEPS+1];

    logic [62:0]   prod;
    logic [DW-1:0] d0;

    assign prod = 63'(i_damping) * 63'(i_item.nu);
    assign d0   = ONE_D + DW'(prod >> F);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid[0] <= 1'b0;
        else if (i_adv) r_valid[0] <= i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_item[0] <= i_item;
            r_idx[0]  <= i_idx;
            r_d[0]    <= d0;
            r_rh[0]   <= DW'(i_drive >> (32 - F));
            r_num[0]  <= i_drive << F;
            r_qh[0]   <= '0;
            r_rg[0]   <= HALF_D;
            r_qg[0]   <= '0;
        end
    end

    for (genvar k = 0; k < H_STEPS; k++) begin : g_step
        logic [DW:0] dd, rh2, rg2, sub_h, sub_g;
        logic        ge_h, ge_g;

        always_comb begin
            dd    = {1'b0, r_d[k]};
            rh2   = {r_rh[k], r_num[k][31]};
            rg2   = {r_rg[k], 1'b0};
            sub_h = rh2 - dd;
            sub_g = rg2 - dd;
            ge_h  = (rh2 >= dd);
            ge_g  = (rg2 >= dd);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_valid[k+1] <= 1'b0;
            else if (i_adv) r_valid[k+1] <= r_valid[k];
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_item[k+1] <= r_item[k];
                r_idx[k+1]  <= r_idx[k];
                r_d[k+1]    <= r_d[k];
                r_num[k+1]  <= {r_num[k][30:0], 1'b0};
                r_rh[k+1]   <= ge_h ? sub_h[DW-1:0] : rh2[DW-1:0];
                r_qh[k+1]   <= {r_qh[k][30:0], ge_h};
                if (k < GSTEPS) begin
                    r_rg[k+1] <= ge_g ? sub_g[DW-1:0] : rg2[DW-1:0];
                    r_qg[k+1] <= {r_qg[k][GSTEPS-2:0], ge_g};
                end else begin
                    r_rg[k+1] <= r_rg[k];
                    r_qg[k+1] <= r_qg[k];
                end
            end
        end
    end

    assign o_valid = r_valid[H_STEPS];
    assign o_item  = r_item[H_STEPS];
    assign o_idx   = r_idx[H_STEPS];
    assign o_qg    = r_qg[H_STEPS];
    assign o_qh    = r_qh[H_STEPS];

endmodule

// File: hdl/pvcn_back.sv
// Back end: node state memories, clearing pass, velocity arithmetic, result register.
// Depends on pvcn_pkg and pvcn_out_if.
module pvcn_back import pvcn_pkg::*; #(
    parameter int NODES = 4096,
    parameter int FRAC_BITS = 16,
    localparam int IW = $clog2(NODES),
    localparam int GSTEPS = FRAC_BITS + 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_item             i_item,
    input  logic [IW-1:0]     i_idx,
    input  logic [GSTEPS-1:0] i_qg,
    input  logic [31:0]       i_qh,
    pvcn_out_if.source        o_out,
    output t_back_status      o_status
);

    localparam int F  = FRAC_BITS;
    localparam int GW = F + 3;
    localparam int PW = 32 + GW;
    localparam int RW = 68 - F;
    localparam logic signed [GW-1:0] ONE_G = GW'(1) << F;

    logic [63:0] mem_vel [NODES];
    logic [63:0] mem_fld [NODES];

    logic          r_clearing;
    logic [IW-1:0] r_clr_addr;

    logic [63:0] r_vel_q, r_fld_q;

    logic                 r_t1_valid;
    t_item                r_t1_item;
    logic [IW-1:0]        r_t1_idx;
    logic signed [GW-1:0] r_t1_g;
    logic [31:0]          r_t1_h;

    logic                 r_t2_valid;
    t_item                r_t2_item;
    logic [IW-1:0]        r_t2_idx;
    logic signed [GW-1:0] r_t2_g;
    logic [31:0]          r_t2_h;
    logic signed [31:0]   r_t2_vx, r_t2_vy;
    logic signed [32:0]   r_t2_sx, r_t2_sy;

    logic                 r_t3_valid;
    t_item                r_t3_item;
    logic [IW-1:0]        r_t3_idx;
    logic signed [31:0]   r_t3_vx, r_t3_vy;
    logic signed [PW-1:0] r_t3_pvx, r_t3_pvy;
    logic signed [49:0]   r_t3_lox, r_t3_hix, r_t3_loy, r_t3_hiy;

    logic               r_out_valid;
    logic signed [31:0] r_out_vx, r_out_vy;
    logic               r_out_sat;

    logic adv_tail, adv_head, hazard;
    logic signed [GW-1:0] g_in;

    logic signed [PW-1:0] shv_x, shv_y;
    logic signed [66:0]   sum_x, sum_y, sht_x, sht_y;
    logic signed [RW-1:0] a_x, a_y, t_x, t_y, r_x, r_y;
    logic                 ok_x, ok_y;
    logic signed [31:0]   nx, ny, res_x, res_y;
    logic                 step_int, res_sat;

    logic          vel_we, fld_we;
    logic [IW-1:0] waddr;
    logic [63:0]   vel_wd, fld_wd;

    assign adv_tail = !r_out_valid || o_out.ready;
    assign hazard   = i_valid && ((r_t1_valid && (r_t1_idx == i_idx)) ||
                                  (r_t2_valid && (r_t2_idx == i_idx)) ||
                                  (r_t3_valid && (r_t3_idx == i_idx)));
    assign adv_head = adv_tail && !hazard;
    assign o_status.adv_head = adv_head;
    assign o_status.clearing = r_clearing;

    assign g_in = $signed({1'b0, i_qg}) - ONE_G;

    // zero all node state after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == IW'(NODES - 1)) r_clearing <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (vel_we) mem_vel[waddr] <= vel_wd;
        if (fld_we) mem_fld[waddr] <= fld_wd;
        if (adv_tail) begin
            r_vel_q <= mem_vel[i_idx];
            r_fld_q <= mem_fld[i_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1_valid  <= 1'b0;
            r_t2_valid  <= 1'b0;
            r_t3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv_tail) begin
            r_t1_valid  <= i_valid && !hazard;
            r_t2_valid  <= r_t1_valid;
            r_t3_valid  <= r_t2_valid;
            r_out_valid <= r_t3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_tail) begin
            r_t1_item <= i_item;
            r_t1_idx  <= i_idx;
            r_t1_g    <= g_in;
            r_t1_h    <= i_qh;

            r_t2_item <= r_t1_item;
            r_t2_idx  <= r_t1_idx;
            r_t2_g    <= r_t1_g;
            r_t2_h    <= r_t1_h;
            r_t2_vx   <= $signed(r_vel_q[63:32]);
            r_t2_vy   <= $signed(r_vel_q[31:0]);
            r_t2_sx   <= 33'(r_t1_item.ex) + 33'($signed(r_fld_q[63:32]));
            r_t2_sy   <= 33'(r_t1_item.ey) + 33'($signed(r_fld_q[31:0]));

            r_t3_item <= r_t2_item;
            r_t3_idx  <= r_t2_idx;
            r_t3_vx   <= r_t2_vx;
            r_t3_vy   <= r_t2_vy;
            r_t3_pvx  <= PW'(r_t2_vx) * PW'(r_t2_g);
            r_t3_pvy  <= PW'(r_t2_vy) * PW'(r_t2_g);
            r_t3_lox  <= 50'(r_t2_sx) * 50'($signed({1'b0, r_t2_h[H_SPLIT-1:0]}));
            r_t3_hix  <= 50'(r_t2_sx) * 50'($signed({1'b0, r_t2_h[31:H_SPLIT]}));
            r_t3_loy  <= 50'(r_t2_sy) * 50'($signed({1'b0, r_t2_h[H_SPLIT-1:0]}));
            r_t3_hiy  <= 50'(r_t2_sy) * 50'($signed({1'b0, r_t2_h[31:H_SPLIT]}));

            if (r_t3_valid) begin
                r_out_vx  <= res_x;
                r_out_vy  <= res_y;
                r_out_sat <= res_sat;
            end
        end
    end

    always_comb begin
        shv_x = r_t3_pvx >>> F;
        shv_y = r_t3_pvy >>> F;
        a_x   = RW'($signed(shv_x[PW-F-1:0]));
        a_y   = RW'($signed(shv_y[PW-F-1:0]));
        sum_x = (67'(r_t3_hix) <<< H_SPLIT) + 67'(r_t3_lox);
        sum_y = (67'(r_t3_hiy) <<< H_SPLIT) + 67'(r_t3_loy);
        sht_x = sum_x >>> F;
        sht_y = sum_y >>> F;
        t_x   = RW'($signed(sht_x[66-F:0]));
        t_y   = RW'($signed(sht_y[66-F:0]));
        r_x   = a_x - t_x;
        r_y   = a_y - t_y;
        ok_x  = (&r_x[RW-1:31]) || !(|r_x[RW-1:31]);
        ok_y  = (&r_y[RW-1:31]) || !(|r_y[RW-1:31]);
        nx    = ok_x ? r_x[31:0] : (r_x[RW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff);
        ny    = ok_y ? r_y[31:0] : (r_y[RW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff);

        step_int = r_t3_item.in_range && r_t3_item.interior && (r_t3_item.mode == MODE_STEP);
        res_sat  = step_int && !(ok_x && ok_y);
        if (!r_t3_item.in_range) begin
            res_x = '0;
            res_y = '0;
        end else if (r_t3_item.mode == MODE_LOAD) begin
            res_x = r_t3_item.ivx;
            res_y = r_t3_item.ivy;
        end else if (r_t3_item.interior) begin
            res_x = nx;
            res_y = ny;
        end else begin
            res_x = r_t3_vx;
            res_y = r_t3_vy;
        end

        if (r_clearing) begin
            vel_we = 1'b1;
            fld_we = 1'b1;
            waddr  = r_clr_addr;
            vel_wd = '0;
            fld_wd = '0;
        end else begin
            vel_we = adv_tail && r_t3_valid && r_t3_item.in_range &&
                     ((r_t3_item.mode == MODE_LOAD) || r_t3_item.interior);
            fld_we = adv_tail && r_t3_valid && r_t3_item.in_range &&
                     (r_t3_item.mode == MODE_STEP);
            waddr  = r_t3_idx;
            vel_wd = {res_x, res_y};
            fld_wd = {r_t3_item.ex, r_t3_item.ey};
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.vel_x_out = r_out_vx;
    assign o_out.vel_y_out = r_out_vy;
    assign o_out.saturated = r_out_sat;

endmodule

// File: hdl/plasma_velocity_cn_update_unit.sv
// Top level: registers, front queue, coefficient pipeline, back end.
// One item per cycle sustained unless output back-pressure or a node hazard stalls.
// An item whose node is still in one of the last three arithmetic stages waits
// for it, a wait set by the state memory read-modify-write loop.
// Reset is synchronous; after it a clearing pass over all MAX_COLS*MAX_ROWS nodes
// zeros node state while no input is taken (register writes still are).
module plasma_velocity_cn_update_unit import pvcn_pkg::*; #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pvcn_cfg_if.sink   i_cfg,
    pvcn_in_if.sink    i_in,
    pvcn_out_if.source o_out
);

    localparam int NODES  = MAX_COLS * MAX_ROWS;
    localparam int IW     = $clog2(NODES);
    localparam int GSTEPS = FRAC_BITS + 2;

    t_cfg r_cfg;

    logic              q_valid;
    t_item             q_item;
    logic [IW-1:0]     q_idx;
    logic              d_valid;
    t_item             d_item;
    logic [IW-1:0]     d_idx;
    logic [GSTEPS-1:0] d_qg;
    logic [31:0]       d_qh;
    t_back_status      status;
    logic              pop;

    assign i_cfg.ready = 1'b1;
    assign pop = status.adv_head && q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_DAMPING: r_cfg.damping <= i_cfg.data;
                REG_DRIVE:   r_cfg.drive   <= i_cfg.data;
                REG_COLS:    r_cfg.cols    <= i_cfg.data[6:0];
                REG_ROWS:    r_cfg.rows    <= i_cfg.data[6:0];
                default: begin
                end
            endcase
        end
    end

    pvcn_front #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg      (r_cfg),
        .i_clearing (status.clearing),
        .i_pop      (pop),
        .o_q_valid  (q_valid),
        .o_q_item   (q_item),
        .o_q_idx    (q_idx)
    );

    pvcn_div #(.NODES(NODES), .FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (status.adv_head),
        .i_valid   (q_valid),
        .i_item    (q_item),
        .i_idx     (q_idx),
        .i_damping (r_cfg.damping),
        .i_drive   (r_cfg.drive),
        .o_valid   (d_valid),
        .o_item    (d_item),
        .o_idx     (d_idx),
        .o_qg      (d_qg),
        .o_qh      (d_qh)
    );

    pvcn_back #(.NODES(NODES), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (d_valid),
        .i_item   (d_item),
        .i_idx    (d_idx),
        .i_qg     (d_qg),
        .i_qh     (d_qh),
        .o_out    (o_out),
        .o_status (status)
    );

`ifndef SYNTHESIS
    a_no_input_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.clearing |-> !i_in.ready)
        else $error("input taken during clearing pass");

    a_no_result_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.clearing |-> !o_out.valid)
        else $error("result during clearing pass");

    a_sat_clips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.saturated) |->
            (o_out.vel_x_out == 32'sh7fff_ffff || o_out.vel_x_out == 32'sh8000_0000 ||
             o_out.vel_y_out == 32'sh7fff_ffff || o_out.vel_y_out == 32'sh8000_0000))
        else $error("saturated flag without clipped velocity");
`endif

endmodule
